// ===== sv/stable_priority_queue_assert.svh =====
// Assertion macros shared by the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("stable_priority_queue: assertion failed");
`define SPQ_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("stable_priority_queue: invariant violated");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== sv/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
package spq_pkg;

	localparam int SPQ_DEPTH = 16;

	typedef enum logic [1:0] {
		FN_ENQUEUE  = 2'd0,
		FN_DEQUEUE  = 2'd1,
		FN_TRAVERSE = 2'd2,
		FN_NOP      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_TRAVERSE
	} fsm_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   ent;
	} cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  logic               tail,
	input  logic               left_occ,
	input  spq_pkg::entry_t    left_ent,
	input  spq_pkg::entry_t    right_ent,
	input  spq_pkg::entry_t    front_ent,
	output spq_pkg::entry_t    ent_q
);

	logic left_moves;
	logic new_here;

	// The left neighbor is pushed right when the new item outranks it strictly.
	assign left_moves = left_occ && ($signed(left_ent.prio) < $signed(cmd.ent.prio));
	assign new_here   = !occ || ($signed(ent_q.prio) < $signed(cmd.ent.prio));

	always_ff @(posedge clk) begin
		case (cmd.op)
			spq_pkg::CELL_INSERT: begin
				if (left_moves) begin
					ent_q <= left_ent;
				end else if (new_here) begin
					ent_q <= cmd.ent;
				end
			end
			spq_pkg::CELL_POP: begin
				ent_q <= right_ent;
			end
			spq_pkg::CELL_ROTATE: begin
				if (tail) begin
					ent_q <= front_ent;
				end else if (occ) begin
					ent_q <= right_ent;
				end
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

// ===== sv/stable_priority_queue.sv =====
// Stable bounded priority queue built as a chain of sorted cells.
// Input channel s_axis: tuser carries the operation (enqueue, dequeue,
// traverse), tdata the value and priority for an enqueue.
// Output channel m_axis: one item per result with status in tuser, the
// entry and occupancy in tdata, and tlast on the final item of an operation.
// Enqueue and dequeue are done in the cycle the item is accepted, and the
// result is registered, so it appears in the cycle after. All cells compare
// against the new priority at once, so the insert point costs no search.
// During a traverse of a non-empty queue the chain rotates by one cell per
// emitted item and is back in order after the last one. No new item is
// accepted meanwhile. When the receiver stalls, the output register holds
// its item and the input side is held off until the slot frees. Reset
// empties the queue; cell contents are not cleared and are never read
// while unoccupied.
`include "stable_priority_queue_assert.svh"
module stable_priority_queue #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int OUT_W = ((48 + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [47:0]      s_axis_tdata,  // item_value[31:0], item_priority[47:32]
	input  logic [1:0]       s_axis_tuser,  // func[1:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // out_value, out_priority, occupancy, zero pad
	output logic [1:0]       m_axis_tuser,  // status[1:0]
	output logic             m_axis_tlast
);

	spq_pkg::fsm_t      state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      rem_q, rem_d;
	spq_pkg::cell_cmd_t cmd;
	spq_pkg::entry_t    ent [DEPTH];
	logic [DEPTH-1:0]   occ;
	logic [DEPTH-1:0]   tail;

	logic               out_free;
	logic               s_fire;
	logic               res_load;
	spq_pkg::status_t   res_status;
	spq_pkg::entry_t    res_ent;
	logic               res_last;

	logic               m_valid_q;
	spq_pkg::status_t   res_status_q;
	spq_pkg::entry_t    res_ent_q;
	logic [CW-1:0]      res_occ_q;
	logic               res_last_q;

	assign out_free = !m_valid_q || m_axis_tready;
	assign s_fire   = s_axis_tvalid && s_axis_tready;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign occ[gi]  = (CW'(gi) < count_q);
			assign tail[gi] = (CW'(gi + 1) == count_q);
			spq_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.occ       (occ[gi]),
				.tail      (tail[gi]),
				.left_occ  ((gi == 0) ? 1'b0 : occ[(gi == 0) ? 0 : gi - 1]),
				.left_ent  (ent[(gi == 0) ? 0 : gi - 1]),
				.right_ent (ent[(gi == DEPTH - 1) ? gi : gi + 1]),
				.front_ent (ent[0]),
				.ent_q     (ent[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= spq_pkg::FSM_IDLE;
			count_q   <= '0;
			rem_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status;
			res_ent_q    <= res_ent;
			res_occ_q    <= count_d;
			res_last_q   <= res_last;
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		rem_d         = rem_q;
		cmd.op        = spq_pkg::CELL_HOLD;
		cmd.ent.value = $signed(s_axis_tdata[31:0]);
		cmd.ent.prio  = $signed(s_axis_tdata[47:32]);
		s_axis_tready = 1'b0;
		res_load      = 1'b0;
		res_status    = spq_pkg::ST_OK;
		res_ent       = '0;
		res_last      = 1'b1;
		case (state_q)
			spq_pkg::FSM_IDLE: begin
				s_axis_tready = out_free;
				if (s_fire) begin
					case (spq_pkg::func_t'(s_axis_tuser))
						spq_pkg::FN_ENQUEUE: begin
							res_load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								res_status = spq_pkg::ST_FULL;
							end else begin
								cmd.op  = spq_pkg::CELL_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						spq_pkg::FN_DEQUEUE: begin
							res_load = 1'b1;
							if (count_q == '0) begin
								res_status = spq_pkg::ST_EMPTY;
							end else begin
								cmd.op  = spq_pkg::CELL_POP;
								res_ent = ent[0];
								count_d = count_q - CW'(1);
							end
						end
						spq_pkg::FN_TRAVERSE: begin
							if (count_q == '0) begin
								res_load   = 1'b1;
								res_status = spq_pkg::ST_EMPTY;
							end else begin
								rem_d   = count_q;
								state_d = spq_pkg::FSM_TRAVERSE;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			spq_pkg::FSM_TRAVERSE: begin
				if (out_free) begin
					res_load = 1'b1;
					res_ent  = ent[0];
					res_last = (rem_q == CW'(1));
					cmd.op   = spq_pkg::CELL_ROTATE;
					rem_d    = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = spq_pkg::FSM_IDLE;
					end
				end
			end
			default: begin
				state_d = spq_pkg::FSM_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'({res_occ_q, res_ent_q.prio, res_ent_q.value});
	assign m_axis_tuser  = res_status_q;
	assign m_axis_tlast  = res_last_q;

	`SPQ_ASSERT_ALWAYS(a_count_bound, (count_q <= CW'(DEPTH)))
	`SPQ_ASSERT(a_trav_count_stable, (state_q == spq_pkg::FSM_TRAVERSE) |-> $stable(count_q))
	`SPQ_ASSERT(a_trav_rem_nonzero, (state_q == spq_pkg::FSM_TRAVERSE) |-> (rem_q != '0))
	`SPQ_ASSERT(a_enq_grows, (s_fire && (s_axis_tuser == spq_pkg::FN_ENQUEUE) && (count_q != CW'(DEPTH))) |=> (count_q == $past(count_q) + CW'(1)))
	`SPQ_ASSERT(a_trav_no_input, (state_q == spq_pkg::FSM_TRAVERSE) |-> !s_fire)

endmodule

// ===== verif/spq_monitor.sv =====
// Monitor that predicts and checks every result item of the stable priority queue.
module spq_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // item_value[31:0], item_priority[47:32]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,   // out_value[31:0], out_priority[47:32], occupancy[52:48]
	input  logic [1:0]  m_axis_tuser,   // status[1:0]
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          awaited
);

	localparam int DEPTH = spq_pkg::SPQ_DEPTH;

	typedef struct packed {
		spq_pkg::status_t status;
		logic [31:0]      value;
		logic [15:0]      prio;
		logic [4:0]       occupancy;
		logic             tail;
	} queue_result_t;

	// Mirror of the sorted store, front entry at index 0.
	spq_pkg::entry_t mirror[DEPTH];
	int              held;
	queue_result_t   awaited_results[$];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
	endtask

	// Applies one operation to the mirror and queues the result items it causes.
	function automatic void apply_queue_op(input spq_pkg::func_t fn, input spq_pkg::entry_t ent);
		queue_result_t r;
		int pos;
		int i;
		r = '0;
		r.status = spq_pkg::ST_OK;
		r.tail = 1'b1;
		case (fn)
			spq_pkg::FN_ENQUEUE: begin
				if (held == DEPTH) begin
					r.status = spq_pkg::ST_FULL;
				end else begin
					// Equal priorities stay in arrival order.
					pos = 0;
					while (pos < held && $signed(mirror[pos].prio) >= $signed(ent.prio))
						pos++;
					for (i = held; i > pos; i--)
						mirror[i] = mirror[i - 1];
					mirror[pos] = ent;
					held++;
				end
			end
			spq_pkg::FN_DEQUEUE: begin
				if (held == 0) begin
					r.status = spq_pkg::ST_EMPTY;
				end else begin
					r.value = mirror[0].value;
					r.prio = mirror[0].prio;
					for (i = 1; i < held; i++)
						mirror[i - 1] = mirror[i];
					held--;
				end
			end
			spq_pkg::FN_TRAVERSE: begin
				if (held == 0) begin
					r.status = spq_pkg::ST_EMPTY;
				end else begin
					for (i = 0; i < held; i++) begin
						r.value = mirror[i].value;
						r.prio = mirror[i].prio;
						r.occupancy = 5'(held);
						r.tail = (i == held - 1);
						awaited_results.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.occupancy = 5'(held);
		awaited_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t   got;
		queue_result_t   want;
		spq_pkg::entry_t ent;
		if (!arst_n) begin
			held = 0;
			awaited_results.delete();
			awaited <= 0;
		end else begin
			// Results check first: no result can stem from an item taken at this edge.
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = spq_pkg::status_t'(m_axis_tuser);
				got.value = m_axis_tdata[31:0];
				got.prio = m_axis_tdata[47:32];
				got.occupancy = m_axis_tdata[52:48];
				got.tail = m_axis_tlast;
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result item, status", got.status, 0);
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.value !== want.value)
						report_mismatch("out_value", got.value, want.value);
					if (got.prio !== want.prio)
						report_mismatch("out_priority", got.prio, want.prio);
					if (got.occupancy !== want.occupancy)
						report_mismatch("occupancy", got.occupancy, want.occupancy);
					if (got.tail !== want.tail)
						report_mismatch("tlast", got.tail, want.tail);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				ent.value = s_axis_tdata[31:0];
				ent.prio = s_axis_tdata[47:32];
				apply_queue_op(spq_pkg::func_t'(s_axis_tuser), ent);
			end
			awaited <= awaited_results.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, clock, reset and verdict for the stable priority queue.
module testbench;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 300;
	localparam int STEADY_FROM  = 240;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // item_value[31:0], item_priority[47:32]
	logic [1:0]  s_axis_tuser;   // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;   // out_value[31:0], out_priority[47:32], occupancy[52:48]
	logic [1:0]  m_axis_tuser;   // status[1:0]
	logic        m_axis_tlast;
	int          mismatches;
	int          awaited;
	int          cycle_count = 0;
	int          idle_pct = 0;
	logic        steady = 1'b0;

	// Percent thresholds per segment kind: filling, draining, mixed.
	int          enq_cut[3]  = '{65, 25, 45};
	int          deq_cut[3]  = '{85, 80, 80};
	int          trav_cut[3] = '{96, 94, 94};
	logic [15:0] prio_edge[4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

	stable_priority_queue dut (.*);
	spq_monitor watch (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic offer_op(input spq_pkg::func_t fn, input logic [31:0] value,
			input logic [15:0] prio);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {prio, value};
		s_axis_tuser <= fn;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Receiver: accepts in runs and stalls in bursts until the final stretch.
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!steady && $urandom_range(0, 3) != 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(posedge clk);
			end
		end
	end

	initial begin
		int             sent;
		int             seg;
		int             mode;
		int             roll;
		int             i;
		spq_pkg::func_t fn;
		logic [15:0]    prio;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= spq_pkg::FN_NOP;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: dequeue, traverse and the unused code.
		offer_op(spq_pkg::FN_TRAVERSE, 32'hFFFF_FFFF, 16'hFFFF);
		offer_op(spq_pkg::FN_DEQUEUE, 32'h0, 16'h0);
		offer_op(spq_pkg::FN_NOP, 32'h5A5A_5A5A, 16'h1234);
		// Extremes and ties at the top, middle and bottom of the order.
		offer_op(spq_pkg::FN_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
		offer_op(spq_pkg::FN_ENQUEUE, 32'h8000_0000, 16'h8000);
		offer_op(spq_pkg::FN_ENQUEUE, 32'h0000_0000, 16'h0000);
		offer_op(spq_pkg::FN_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
		offer_op(spq_pkg::FN_ENQUEUE, 32'd1, 16'd5);
		offer_op(spq_pkg::FN_ENQUEUE, 32'd2, 16'd5);
		offer_op(spq_pkg::FN_ENQUEUE, 32'h1234_5678, 16'h7FFF);
		offer_op(spq_pkg::FN_ENQUEUE, 32'hA5A5_A5A5, 16'h8000);
		offer_op(spq_pkg::FN_ENQUEUE, 32'd3, 16'd5);
		for (i = 0; i < 7; i++)
			offer_op(spq_pkg::FN_ENQUEUE, $urandom, 16'($urandom_range(0, 4)));
		// The store is full now.
		offer_op(spq_pkg::FN_ENQUEUE, 32'hDEAD_BEEF, 16'h7FFF);
		offer_op(spq_pkg::FN_TRAVERSE, 32'h0, 16'h0);
		offer_op(spq_pkg::FN_NOP, 32'h0, 16'h0);
		offer_op(spq_pkg::FN_DEQUEUE, 32'h0, 16'h0);
		offer_op(spq_pkg::FN_DEQUEUE, 32'h0, 16'h0);

		// Hold the sender until the block has delivered everything.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			idle_pct = steady ? 0 : $urandom_range(0, 2) * 15;
			seg = $urandom_range(15, 45);
			if (seg > RANDOM_ITEMS - sent)
				seg = RANDOM_ITEMS - sent;
			repeat (seg) begin
				if (sent >= STEADY_FROM) begin
					steady = 1'b1;
					idle_pct = 0;
				end
				roll = $urandom_range(0, 99);
				if (roll < enq_cut[mode])
					fn = spq_pkg::FN_ENQUEUE;
				else if (roll < deq_cut[mode])
					fn = spq_pkg::FN_DEQUEUE;
				else if (roll < trav_cut[mode])
					fn = spq_pkg::FN_TRAVERSE;
				else
					fn = spq_pkg::FN_NOP;
				// Mostly a narrow band so that ties are common.
				roll = $urandom_range(0, 99);
				if (roll < 60)
					prio = 16'($urandom_range(0, 6)) - 16'd3;
				else if (roll < 85)
					prio = 16'($urandom);
				else
					prio = prio_edge[$urandom_range(0, 3)];
				offer_op(fn, $urandom, prio);
				sent++;
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== stable_priority_queue.f =====
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
verif/spq_monitor.sv
verif/testbench.sv
